// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- design/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg
// Types, codes and defaults of the burst sequence reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

   localparam int NUM_CHANNELS_DEF    = 8;
   localparam int MAX_BURST_BYTES_DEF = 128;
   localparam int BYTES_PER_WORD      = 8;

   localparam int CHAN_W = 5;
   localparam int SEQ_W  = 2;
   localparam int CNT_W  = 5;
   localparam int WORD_W = 64;

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   localparam logic KIND_ERROR = 1'b0;
   localparam logic KIND_WORD  = 1'b1;

   localparam logic STATUS_SEQ_ERR = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam logic [SEQ_W-1:0] SEQ_OPEN = 2'd0;
   localparam logic [SEQ_W-1:0] SEQ_WRAP = 2'd3;
   localparam logic [SEQ_W-1:0] SEQ_ONE  = 2'd1;

   typedef struct packed {
      logic              cmd;
      logic [CHAN_W-1:0] channel;
      logic [SEQ_W-1:0]  seq;
      logic              last_flag;
      logic [WORD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] chan_out;
      logic              status;
      logic [WORD_W-1:0] word;
      logic              run_end;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // register the accepted transaction
      logic eval_en;    // commit the decision for the held transaction
      logic rd_en;      // read the next stored word of the run
      logic word_load;  // move the read word into the output register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic dec_err;      // held transaction yields an error response
      logic dec_release;  // held transaction closes a burst
      logic out_free;     // output register can take a result this cycle
      logic rel_last;     // current run word is the final one
   } dp_status_type;

endpackage

// ----- design/bsr_stream_if.sv -----
// ----------------------------------------------------------------------------
// bsr_stream_if
// Valid/ready stream channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface bsr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- design/bsr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsr_ctrl
// Sequencer: accept, evaluate, then stream stored words of a closed burst.
// ----------------------------------------------------------------------------
module bsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bsr_pkg::dp_status_type sts,
   output bsr_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no transaction is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // an error response waits for room in the output register
            if (!sts.dec_err || sts.out_free) begin
               cmd.eval_en = 1'b1;
               state_in    = sts.dec_release ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (sts.out_free) begin
               cmd.word_load = 1'b1;
               state_in      = sts.rel_last ? ST_IDLE : ST_READ;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/bsr_datapath.sv -----
// ----------------------------------------------------------------------------
// bsr_datapath
// Per-channel burst state, word store, decision logic and output register.
// ----------------------------------------------------------------------------
module bsr_datapath #(
   parameter int NUM_CHANNELS    = bsr_pkg::NUM_CHANNELS_DEF,
   parameter int MAX_BURST_BYTES = bsr_pkg::MAX_BURST_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bsr_pkg::req_type       req_data,
   input  bsr_pkg::ctrl_cmd_type  cmd,
   output bsr_pkg::dp_status_type sts,
   output logic                   rsp_valid,
   output bsr_pkg::rsp_type       rsp_data,
   input  logic                   rsp_ready
);

   localparam int WPC    = MAX_BURST_BYTES / bsr_pkg::BYTES_PER_WORD;
   localparam int DEPTH  = NUM_CHANNELS * WPC;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W  = bsr_pkg::CNT_W;
   localparam int SEQ_W  = bsr_pkg::SEQ_W;
   localparam logic [CNT_W:0] NUM_CHAN_X = (CNT_W+1)'(NUM_CHANNELS);
   localparam logic [CNT_W:0] WPC_X      = (CNT_W+1)'(WPC);

   // held transaction
   bsr_pkg::req_type item_ff;

   // per-channel burst state
   logic             active_ff [NUM_CHANNELS];
   logic [CNT_W-1:0] count_ff  [NUM_CHANNELS];
   logic [SEQ_W-1:0] exp_ff    [NUM_CHANNELS];

   // word store, no reset: only words of the current burst are read back
   logic [bsr_pkg::WORD_W-1:0] burst_mem [DEPTH];
   logic [bsr_pkg::WORD_W-1:0] rd_data_ff;

   logic [CNT_W-1:0] rel_idx_ff;
   logic [CNT_W-1:0] rel_total_ff;

   logic             out_valid_ff;
   bsr_pkg::rsp_type out_ff;

   logic [IDX_W-1:0]  chan_idx;
   logic              chan_bad;
   logic              act;
   logic [CNT_W-1:0]  cnt_cur;
   logic [CNT_W-1:0]  cnt_next;
   logic [SEQ_W-1:0]  seq_next;
   logic              dec_err;
   logic              err_status;
   logic              drop_burst;
   logic              dec_store;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign chan_idx = IDX_W'(item_ff.channel);
   assign chan_bad = {1'b0, item_ff.channel} >= NUM_CHAN_X;
   assign act      = active_ff[chan_idx];
   assign cnt_cur  = act ? count_ff[chan_idx] : '0;
   assign cnt_next = cnt_cur + CNT_W'(1);
   assign seq_next = (item_ff.seq == bsr_pkg::SEQ_OPEN || item_ff.seq == bsr_pkg::SEQ_WRAP)
                     ? bsr_pkg::SEQ_ONE : item_ff.seq + SEQ_W'(1);

   always_comb begin
      dec_err    = 1'b0;
      err_status = bsr_pkg::STATUS_SEQ_ERR;
      drop_burst = 1'b0;
      dec_store  = 1'b0;
      priority if (item_ff.cmd == bsr_pkg::CMD_RESET) begin
         dec_err = 1'b0;
      end else if (chan_bad) begin
         dec_err    = 1'b1;
         err_status = bsr_pkg::STATUS_INVALID;
      end else if (!act && item_ff.seq != bsr_pkg::SEQ_OPEN) begin
         dec_err = 1'b1;
      end else if (act && item_ff.seq != exp_ff[chan_idx]) begin
         dec_err    = 1'b1;
         drop_burst = 1'b1;
      end else if (({1'b0, cnt_cur} + (CNT_W+1)'(1)) > WPC_X) begin
         dec_err    = 1'b1;
         err_status = bsr_pkg::STATUS_INVALID;
         drop_burst = 1'b1;
      end else begin
         dec_store = 1'b1;
      end
   end

   assign wr_addr = ADDR_W'(int'(chan_idx) * WPC + int'(cnt_cur));
   assign rd_addr = ADDR_W'(int'(chan_idx) * WPC + int'(rel_idx_ff));

   assign sts.dec_err     = dec_err;
   assign sts.dec_release = dec_store && item_ff.last_flag;
   assign sts.out_free    = !out_valid_ff || rsp_ready;
   assign sts.rel_last    = (rel_idx_ff + CNT_W'(1)) == rel_total_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
            count_ff[i]  <= '0;
            exp_ff[i]    <= '0;
         end
      end else if (cmd.eval_en) begin
         if (item_ff.cmd == bsr_pkg::CMD_RESET) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               active_ff[i] <= 1'b0;
               count_ff[i]  <= '0;
               exp_ff[i]    <= '0;
            end
         end else if (drop_burst) begin
            active_ff[chan_idx] <= 1'b0;
         end else if (dec_store) begin
            active_ff[chan_idx] <= !item_ff.last_flag;
            count_ff[chan_idx]  <= cnt_next;
            exp_ff[chan_idx]    <= seq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_en && dec_store) begin
         burst_mem[wr_addr] <= item_ff.payload;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= burst_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_en) begin
         rel_idx_ff   <= '0;
         rel_total_ff <= cnt_next;
      end else if (cmd.word_load) begin
         rel_idx_ff <= rel_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((cmd.eval_en && dec_err) || cmd.word_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_en && dec_err) begin
         out_ff.kind     <= bsr_pkg::KIND_ERROR;
         out_ff.chan_out <= item_ff.channel;
         out_ff.status   <= err_status;
         out_ff.word     <= '0;
         out_ff.run_end  <= 1'b1;
      end else if (cmd.word_load) begin
         out_ff.kind     <= bsr_pkg::KIND_WORD;
         out_ff.chan_out <= item_ff.channel;
         out_ff.status   <= bsr_pkg::STATUS_SEQ_ERR;
         out_ff.word     <= rd_data_ff;
         out_ff.run_end  <= sts.rel_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- design/burst_sequence_reassembler.sv -----
// ----------------------------------------------------------------------------
// burst_sequence_reassembler
// Collects multi-packet bursts per channel and releases them as word runs.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one transaction per packet or reset command (valid/ready).
//   rsp_chan delivers results: an error response, or the stored words of a
//   closed burst, oldest first, run_end set on the final result.
//   A packet or command is accepted in the idle state, then evaluated in the
//   eval state, which updates the channel state (read-modify-write of the
//   channel registers plus at most one store write). A closing packet then
//   streams its N words, each as a store read, then an output load, before
//   the next packet is accepted. An error response is loaded into the output
//   register at evaluation; the first word of a run at its first output load.
//   One result register sits on rsp_chan: a new packet is accepted while a
//   result waits; if the receiver stalls, the next result holds the block
//   until the register frees up.
//   Reset clears channel state and the output register; the
//   word store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module burst_sequence_reassembler #(
   parameter int NUM_CHANNELS    = bsr_pkg::NUM_CHANNELS_DEF,
   parameter int MAX_BURST_BYTES = bsr_pkg::MAX_BURST_BYTES_DEF
) (
   input logic          clock,
   input logic          reset,
   bsr_stream_if.sink   req_chan,
   bsr_stream_if.source rsp_chan
);

   bsr_pkg::ctrl_cmd_type  dp_cmd;
   bsr_pkg::dp_status_type dp_sts;

   bsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   bsr_datapath #(
      .NUM_CHANNELS    (NUM_CHANNELS),
      .MAX_BURST_BYTES (MAX_BURST_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_chan.data),
      .cmd       (dp_cmd),
      .sts       (dp_sts),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_chan.data),
      .rsp_ready (rsp_chan.ready)
   );

   `ASSERT_IMPLIES(a_word_into_free_slot, clock, reset, dp_cmd.word_load, dp_sts.out_free)
   `ASSERT_IMPLIES(a_err_into_free_slot, clock, reset,
                   dp_cmd.eval_en && dp_sts.dec_err, dp_sts.out_free)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ASSERT_IMPLIES(a_one_command, clock, reset, 1'b1,
                   $onehot0({dp_cmd.capture, dp_cmd.eval_en, dp_cmd.rd_en, dp_cmd.word_load}))

endmodule

// ----- dv/burst_reassembly_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_reassembly_checker
// Watches both channels of the burst sequence reassembler, tracks every
// channel's burst state from the accepted packets, queues the words and
// error responses they must produce, and compares each delivered result
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module burst_reassembly_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bsr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bsr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   localparam int CHANNELS    = bsr_pkg::NUM_CHANNELS_DEF;
   localparam int BURST_WORDS = bsr_pkg::MAX_BURST_BYTES_DEF / bsr_pkg::BYTES_PER_WORD;
   localparam int CHAN_W      = bsr_pkg::CHAN_W;
   localparam int SEQ_W       = bsr_pkg::SEQ_W;
   localparam int CNT_W       = bsr_pkg::CNT_W;
   localparam int WORD_W      = bsr_pkg::WORD_W;
   localparam logic NO_STATUS = 1'b0;

   logic              chan_open     [CHANNELS];
   logic [CNT_W-1:0]  chan_words    [CHANNELS];
   logic [SEQ_W-1:0]  chan_next_seq [CHANNELS];
   logic [WORD_W-1:0] burst_store   [CHANNELS][BURST_WORDS];

   bsr_pkg::rsp_type expected_results[$];
   int               mismatches   = 0;
   int               results_owed = 0;

   assign fail_count = mismatches;
   assign pending    = results_owed;

   function automatic void clear_channels();
      foreach (chan_open[i]) begin
         chan_open[i]     = 1'b0;
         chan_words[i]    = '0;
         chan_next_seq[i] = bsr_pkg::SEQ_OPEN;
      end
   endfunction

   function automatic void expect_result(logic kind, logic [CHAN_W-1:0] chan,
                                         logic status, logic [WORD_W-1:0] word,
                                         logic run_end);
      bsr_pkg::rsp_type res;
      res.kind     = kind;
      res.chan_out = chan;
      res.status   = status;
      res.word     = word;
      res.run_end  = run_end;
      expected_results.push_back(res);
   endfunction

   // Per-channel burst tracking; one packet in, zero or more results queued.
   task automatic reassemble(input bsr_pkg::req_type pkt);
      int ch;
      int words;
      ch = pkt.channel;
      if (pkt.cmd == bsr_pkg::CMD_RESET) begin
         clear_channels();
         return;
      end
      if (ch >= CHANNELS) begin
         expect_result(bsr_pkg::KIND_ERROR, pkt.channel, bsr_pkg::STATUS_INVALID, '0, 1'b1);
         return;
      end
      if (!chan_open[ch]) begin
         if (pkt.seq != bsr_pkg::SEQ_OPEN) begin
            expect_result(bsr_pkg::KIND_ERROR, pkt.channel, bsr_pkg::STATUS_SEQ_ERR,
                          '0, 1'b1);
            return;
         end
         chan_open[ch]     = 1'b1;
         chan_words[ch]    = '0;
         chan_next_seq[ch] = bsr_pkg::SEQ_OPEN;
      end else if (pkt.seq != chan_next_seq[ch]) begin
         chan_open[ch] = 1'b0;
         expect_result(bsr_pkg::KIND_ERROR, pkt.channel, bsr_pkg::STATUS_SEQ_ERR, '0, 1'b1);
         return;
      end
      words = chan_words[ch];
      if (words >= BURST_WORDS) begin
         chan_open[ch] = 1'b0;
         expect_result(bsr_pkg::KIND_ERROR, pkt.channel, bsr_pkg::STATUS_INVALID, '0, 1'b1);
         return;
      end
      burst_store[ch][words] = pkt.payload;
      words++;
      chan_words[ch] = CNT_W'(words);
      // after the opener or 3 the sequence wraps to 1
      if (pkt.seq == bsr_pkg::SEQ_OPEN || pkt.seq == bsr_pkg::SEQ_WRAP)
         chan_next_seq[ch] = bsr_pkg::SEQ_ONE;
      else
         chan_next_seq[ch] = pkt.seq + bsr_pkg::SEQ_ONE;
      if (pkt.last_flag) begin
         chan_open[ch] = 1'b0;
         for (int i = 0; i < words; i++)
            expect_result(bsr_pkg::KIND_WORD, pkt.channel, NO_STATUS, burst_store[ch][i],
                          i == words - 1);
      end
   endtask

   always @(posedge clock) begin
      bsr_pkg::rsp_type want;
      if (reset) begin
         clear_channels();
         expected_results.delete();
      end else begin
         // a result accepted now always belongs to an earlier packet
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d chan_out %0d word %h",
                      rsp_data.kind, rsp_data.chan_out, rsp_data.word);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_data.kind);
                  mismatches++;
               end
               if (rsp_data.chan_out !== want.chan_out) begin
                  $error("chan_out: expected %0d, actual %0d",
                         want.chan_out, rsp_data.chan_out);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.word !== want.word) begin
                  $error("word: expected %h, actual %h", want.word, rsp_data.word);
                  mismatches++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $error("run_end: expected %0d, actual %0d",
                         want.run_end, rsp_data.run_end);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            reassemble(req_data);
      end
      results_owed = expected_results.size();
   end

endmodule

// ----- dv/burst_sequence_reassembler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_sequence_reassembler_tb
// Drives packets and reset commands into the reassembler: a directed set of
// corner cases, then interleaved bursts on random channels mixed with broken
// sequences, overflows and unknown channels, under random backpressure.
// ----------------------------------------------------------------------------
module burst_sequence_reassembler_tb;

   localparam int CHANNELS     = bsr_pkg::NUM_CHANNELS_DEF;
   localparam int BURST_WORDS  = bsr_pkg::MAX_BURST_BYTES_DEF / bsr_pkg::BYTES_PER_WORD;
   localparam int CHAN_W       = bsr_pkg::CHAN_W;
   localparam int SEQ_W        = bsr_pkg::SEQ_W;
   localparam int WORD_W       = bsr_pkg::WORD_W;
   localparam int RANDOM_ITEMS = 310;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 2 + 2 * BURST_WORDS + 16;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset;
   bit   steady   = 1'b0;
   bit   hold_rsp = 1'b0;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;

   // stimulus-side view of each channel, kept in step with the block
   bit         lane_open     [CHANNELS];
   logic [1:0] lane_next_seq [CHANNELS];
   int         lane_count    [CHANNELS];
   int         lane_target   [CHANNELS];
   int         lane = 0;

   bsr_stream_if #(.payload_type(bsr_pkg::req_type)) req_chan ();
   bsr_stream_if #(.payload_type(bsr_pkg::rsp_type)) rsp_chan ();

   always #10 clock = ~clock;

   burst_sequence_reassembler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   burst_reassembly_checker reassembly_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_data   (req_chan.data),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_data   (rsp_chan.data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("burst_sequence_reassembler regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 36);
            @(posedge clock);
         end
      end
   end

   function automatic bsr_pkg::req_type make_packet(logic cmd, logic [CHAN_W-1:0] chan,
                                                    logic [SEQ_W-1:0] seq, logic last,
                                                    logic [WORD_W-1:0] payload);
      bsr_pkg::req_type pkt;
      pkt.cmd       = cmd;
      pkt.channel   = chan;
      pkt.seq       = seq;
      pkt.last_flag = last;
      pkt.payload   = payload;
      return pkt;
   endfunction

   function automatic logic [WORD_W-1:0] rand_payload();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_item(input bsr_pkg::req_type pkt);
      if (!steady && $urandom_range(0, 99) < 36) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= pkt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_random_item();
      int               pick;
      logic [SEQ_W-1:0] seq;
      logic             last;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         send_item(make_packet(bsr_pkg::CMD_RESET, CHAN_W'($urandom), SEQ_W'($urandom),
                               1'($urandom), rand_payload()));
         foreach (lane_open[i]) lane_open[i] = 1'b0;
      end else if (pick < 11) begin
         send_item(make_packet(bsr_pkg::CMD_DATA, CHAN_W'($urandom_range(CHANNELS, 31)),
                               SEQ_W'($urandom), 1'($urandom), rand_payload()));
      end else begin
         // stay on one channel most of the time so long bursts complete
         if ($urandom_range(0, 99) < 40) lane = $urandom_range(0, CHANNELS - 1);
         if (pick < 18) begin
            // sequence guaranteed wrong for the channel's current state
            if (lane_open[lane])
               seq = lane_next_seq[lane] + SEQ_W'($urandom_range(1, 3));
            else
               seq = SEQ_W'($urandom_range(1, 3));
            lane_open[lane] = 1'b0;
            send_item(make_packet(bsr_pkg::CMD_DATA, CHAN_W'(lane), seq, 1'($urandom),
                                  rand_payload()));
         end else begin
            if (!lane_open[lane]) begin
               lane_open[lane]     = 1'b1;
               lane_count[lane]    = 0;
               lane_next_seq[lane] = bsr_pkg::SEQ_OPEN;
               pick = $urandom_range(0, 99);
               if (pick < 10)      lane_target[lane] = BURST_WORDS;
               else if (pick < 16) lane_target[lane] = BURST_WORDS + 1;  // overflow
               else                lane_target[lane] = $urandom_range(1, 6);
            end
            seq = lane_next_seq[lane];
            if (lane_count[lane] == BURST_WORDS) begin
               last = 1'($urandom);
               lane_open[lane] = 1'b0;
            end else begin
               last = (lane_count[lane] + 1 == lane_target[lane]);
               if (last) lane_open[lane] = 1'b0;
            end
            lane_count[lane]++;
            lane_next_seq[lane] = (seq == bsr_pkg::SEQ_OPEN || seq == bsr_pkg::SEQ_WRAP)
                                  ? bsr_pkg::SEQ_ONE : seq + bsr_pkg::SEQ_ONE;
            send_item(make_packet(bsr_pkg::CMD_DATA, CHAN_W'(lane), seq, last,
                                  rand_payload()));
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      reset = 1'b1;
      foreach (lane_open[i]) lane_open[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // continuation with no open burst, then unknown channels
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd0, 2'd2, 1'b0, '0));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd31, 2'd0, 1'b1, '1));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd8, 2'd3, 1'b0, rand_payload()));
      // sequence wraps 3 -> 1
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd7, 2'd0, 1'b0, '0));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd7, 2'd1, 1'b0, '1));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd7, 2'd2, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd7, 2'd3, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd7, 2'd1, 1'b1, rand_payload()));
      // single-packet burst
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd0, 2'd0, 1'b1, 64'h0123_4567_89AB_CDEF));
      // mismatch drops the burst, the retry then hits a closed channel
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd1, 2'd0, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd1, 2'd2, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd1, 2'd1, 1'b1, rand_payload()));
      // second opener on an open burst
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd2, 2'd0, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd2, 2'd0, 1'b1, rand_payload()));
      // reset command in the middle of a burst
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd3, 2'd0, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_RESET, 5'd31, 2'd3, 1'b1, '1));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd3, 2'd1, 1'b1, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd3, 2'd0, 1'b1, rand_payload()));
      // two interleaved bursts
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd5, 2'd0, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd6, 2'd0, 1'b0, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd5, 2'd1, 1'b1, rand_payload()));
      send_item(make_packet(bsr_pkg::CMD_DATA, 5'd6, 2'd1, 1'b1, rand_payload()));
      wait_drained();

      hold_rsp = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 150 && n < 220);
         if (n == 240) wait_drained();
         send_random_item();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("burst_sequence_reassembler regression: pass");
      else
         $display("burst_sequence_reassembler regression: fail");
      $finish;
   end

endmodule
